// ----- src/cts_pkg.sv -----
package cts_pkg;

    localparam int WORD_BYTES = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int KEYWORD_TABLE = 32;

    typedef enum logic [2:0] {
        KIND_DIRECTIVE = 3'd0,
        KIND_COMMENT   = 3'd1,
        KIND_OPERATOR  = 3'd2,
        KIND_PUNCT     = 3'd3,
        KIND_NUMBER    = 3'd4,
        KIND_IDENT     = 3'd5,
        KIND_KEYWORD   = 3'd6,
        KIND_ERROR     = 3'd7
    } kind_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        kind_t       kind;
        logic [4:0]  sub_code;
        logic [3:0]  type_size;
        logic [15:0] length;
        logic [15:0] start_row;
        logic [15:0] start_col;
        logic        last;
    } out_t;

    typedef struct packed {
        kind_t       kind;
        logic [4:0]  sub;
        logic [15:0] len;
        logic [15:0] row;
        logic [15:0] col;
    } tok_t;

    typedef struct packed {
        tok_t                    t0;
        tok_t                    t1;
        logic                    two;
        logic                    short_word;
        logic [WORD_BYTES*8-1:0] word;
    } rec_t;

    typedef struct packed {
        logic [WORD_BYTES*8-1:0] text;
        logic [3:0]              len;
        logic [3:0]              size;
    } kw_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] idx;
    } lookup_t;

    function automatic logic is_dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alph(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return c == " " || c == 8'h0d || c == 8'h0b || c == 8'h0c || c == 8'h09
            || c == 8'h0a;
    endfunction

    function automatic lookup_t op_idx(input logic [7:0] c);
        lookup_t r;
        r.hit = 1'b1;
        case (c)
            "*": r.idx = 5'd0;
            "-": r.idx = 5'd1;
            "/": r.idx = 5'd2;
            "%": r.idx = 5'd3;
            "!": r.idx = 5'd4;
            "~": r.idx = 5'd5;
            "&": r.idx = 5'd6;
            "|": r.idx = 5'd7;
            "^": r.idx = 5'd8;
            "?": r.idx = 5'd9;
            "(": r.idx = 5'd10;
            ")": r.idx = 5'd11;
            "[": r.idx = 5'd12;
            "]": r.idx = 5'd13;
            "<": r.idx = 5'd14;
            ">": r.idx = 5'd15;
            ".": r.idx = 5'd16;
            default:
            begin
                r.hit = 1'b0;
                r.idx = 5'd0;
            end
        endcase
        return r;
    endfunction

    function automatic lookup_t pun_idx(input logic [7:0] c);
        lookup_t r;
        r.hit = 1'b1;
        case (c)
            ";": r.idx = 5'd0;
            ":": r.idx = 5'd1;
            "{": r.idx = 5'd2;
            "}": r.idx = 5'd3;
            8'h27: r.idx = 5'd4;
            8'h22: r.idx = 5'd5;
            default:
            begin
                r.hit = 1'b0;
                r.idx = 5'd0;
            end
        endcase
        return r;
    endfunction

    function automatic kw_t kw_entry(input logic [4:0] i);
        kw_t k;
        case (i)
            5'd0:  k = '{text: {"auto", 32'd0}, len: 4'd4, size: 4'd0};
            5'd1:  k = '{text: {"break", 24'd0}, len: 4'd5, size: 4'd0};
            5'd2:  k = '{text: {"case", 32'd0}, len: 4'd4, size: 4'd0};
            5'd3:  k = '{text: {"char", 32'd0}, len: 4'd4, size: 4'd1};
            5'd4:  k = '{text: {"const", 24'd0}, len: 4'd5, size: 4'd0};
            5'd5:  k = '{text: "continue", len: 4'd8, size: 4'd0};
            5'd6:  k = '{text: {"default", 8'd0}, len: 4'd7, size: 4'd0};
            5'd7:  k = '{text: {"do", 48'd0}, len: 4'd2, size: 4'd0};
            5'd8:  k = '{text: {"double", 16'd0}, len: 4'd6, size: 4'd8};
            5'd9:  k = '{text: {"else", 32'd0}, len: 4'd4, size: 4'd0};
            5'd10: k = '{text: {"enum", 32'd0}, len: 4'd4, size: 4'd2};
            5'd11: k = '{text: {"extern", 16'd0}, len: 4'd6, size: 4'd0};
            5'd12: k = '{text: {"float", 24'd0}, len: 4'd5, size: 4'd4};
            5'd13: k = '{text: {"for", 40'd0}, len: 4'd3, size: 4'd0};
            5'd14: k = '{text: {"goto", 32'd0}, len: 4'd4, size: 4'd0};
            5'd15: k = '{text: {"if", 48'd0}, len: 4'd2, size: 4'd0};
            5'd16: k = '{text: {"int", 40'd0}, len: 4'd3, size: 4'd4};
            5'd17: k = '{text: {"long", 32'd0}, len: 4'd4, size: 4'd8};
            5'd18: k = '{text: "register", len: 4'd8, size: 4'd0};
            5'd19: k = '{text: {"return", 16'd0}, len: 4'd6, size: 4'd0};
            5'd20: k = '{text: {"short", 24'd0}, len: 4'd5, size: 4'd2};
            5'd21: k = '{text: {"signed", 16'd0}, len: 4'd6, size: 4'd1};
            5'd22: k = '{text: {"sizeof", 16'd0}, len: 4'd6, size: 4'd0};
            5'd23: k = '{text: {"static", 16'd0}, len: 4'd6, size: 4'd0};
            5'd24: k = '{text: {"struct", 16'd0}, len: 4'd6, size: 4'd0};
            5'd25: k = '{text: {"switch", 16'd0}, len: 4'd6, size: 4'd0};
            5'd26: k = '{text: {"typedef", 8'd0}, len: 4'd7, size: 4'd0};
            5'd27: k = '{text: {"union", 24'd0}, len: 4'd5, size: 4'd0};
            5'd28: k = '{text: "unsigned", len: 4'd8, size: 4'd4};
            5'd29: k = '{text: {"void", 32'd0}, len: 4'd4, size: 4'd0};
            5'd30: k = '{text: "volatile", len: 4'd8, size: 4'd0};
            default: k = '{text: {"while", 24'd0}, len: 4'd5, size: 4'd0};
        endcase
        return k;
    endfunction

endpackage

// ----- src/cts_front.sv -----
module cts_front #(
    parameter int KEYWORD_MAX_LEN = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  cts_pkg::in_t item,
    input  logic         accept,
    output cts_pkg::rec_t rec,
    output logic         rec_valid
);
    import cts_pkg::*;

    typedef enum logic [7:0] {
        M_IDLE       = 8'b0000_0001,
        M_PENDING    = 8'b0000_0010,
        M_DIRECTIVE  = 8'b0000_0100,
        M_LINE       = 8'b0000_1000,
        M_BLOCK      = 8'b0001_0000,
        M_BLOCK_STAR = 8'b0010_0000,
        M_NUMBER     = 8'b0100_0000,
        M_IDENT      = 8'b1000_0000
    } mode_t;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    mode_t                  mode_reg, mode_next;
    logic [COUNT_WIDTH-1:0] len_reg, len_next;
    logic [COUNT_WIDTH-1:0] trow_reg, trow_next;
    logic [COUNT_WIDTH-1:0] tcol_reg, tcol_next;
    logic [COUNT_WIDTH-1:0] crow_reg, crow_next;
    logic [COUNT_WIDTH-1:0] ccol_reg, ccol_next;
    logic [7:0]             pend_reg, pend_next;
    logic [7:0]             word_reg [WORD_BYTES];
    logic [7:0]             word_next [WORD_BYTES];

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic tok_t mk_tok(input kind_t k, input logic [4:0] s,
                                    input logic [COUNT_WIDTH-1:0] l,
                                    input logic [COUNT_WIDTH-1:0] r,
                                    input logic [COUNT_WIDTH-1:0] c);
        tok_t t;
        t.kind = k;
        t.sub = s;
        t.len = 16'(l);
        t.row = 16'(r);
        t.col = 16'(c);
        return t;
    endfunction

    logic       a_v, b_v, do_start;
    tok_t       a, b;
    logic [7:0] c;
    lookup_t    opl, pnl, pendl;
    logic [COUNT_WIDTH-1:0] inc_len;

    always_comb
    begin
        c = item.ch;
        opl = op_idx(c);
        pnl = pun_idx(c);
        pendl = op_idx(pend_reg);
        inc_len = sat_inc(len_reg);
        mode_next = mode_reg;
        len_next = len_reg;
        trow_next = trow_reg;
        tcol_next = tcol_reg;
        crow_next = crow_reg;
        ccol_next = ccol_reg;
        pend_next = pend_reg;
        word_next = word_reg;
        a_v = 1'b0;
        b_v = 1'b0;
        a = '0;
        b = '0;
        do_start = 1'b0;
        if (item.end_of_text)
        begin
            a_v = 1'b1;
            case (mode_reg)
                M_PENDING: a = mk_tok(KIND_OPERATOR, pendl.idx, len_reg, trow_reg, tcol_reg);
                M_DIRECTIVE: a = mk_tok(KIND_DIRECTIVE, 5'd0, len_reg, trow_reg, tcol_reg);
                M_LINE, M_BLOCK, M_BLOCK_STAR:
                    a = mk_tok(KIND_COMMENT, 5'd0, len_reg, trow_reg, tcol_reg);
                M_NUMBER: a = mk_tok(KIND_NUMBER, 5'd0, len_reg, trow_reg, tcol_reg);
                M_IDENT: a = mk_tok(KIND_IDENT, 5'd0, len_reg, trow_reg, tcol_reg);
                default: a_v = 1'b0;
            endcase
            mode_next = M_IDLE;
            len_next = '0;
        end
        else
        begin
            case (mode_reg)
                M_DIRECTIVE, M_LINE:
                begin
                    len_next = inc_len;
                    if (c == 8'h0a)
                    begin
                        a_v = 1'b1;
                        a = mk_tok((mode_reg == M_DIRECTIVE) ? KIND_DIRECTIVE : KIND_COMMENT,
                                   5'd0, inc_len, trow_reg, tcol_reg);
                        mode_next = M_IDLE;
                        len_next = '0;
                    end
                end
                M_BLOCK:
                begin
                    len_next = inc_len;
                    if (c == "*")
                        mode_next = M_BLOCK_STAR;
                end
                M_BLOCK_STAR:
                begin
                    len_next = inc_len;
                    if (c == "/")
                    begin
                        a_v = 1'b1;
                        a = mk_tok(KIND_COMMENT, 5'd0, inc_len, trow_reg, tcol_reg);
                        mode_next = M_IDLE;
                        len_next = '0;
                    end
                    else if (c != "*")
                        mode_next = M_BLOCK;
                end
                M_NUMBER:
                begin
                    if (is_dig(c) || c == ".")
                        len_next = inc_len;
                    else
                    begin
                        a_v = 1'b1;
                        a = mk_tok(KIND_NUMBER, 5'd0, len_reg, trow_reg, tcol_reg);
                        do_start = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_alph(c) || is_dig(c))
                    begin
                        if (len_reg < COUNT_WIDTH'(KEYWORD_MAX_LEN)
                            && len_reg < COUNT_WIDTH'(WORD_BYTES))
                            word_next[len_reg[2:0]] = c;
                        len_next = inc_len;
                    end
                    else
                    begin
                        a_v = 1'b1;
                        a = mk_tok(KIND_IDENT, 5'd0, len_reg, trow_reg, tcol_reg);
                        do_start = 1'b1;
                    end
                end
                M_PENDING:
                begin
                    if (pend_reg == "/" && c == "/")
                    begin
                        len_next = COUNT_WIDTH'(2);
                        mode_next = M_LINE;
                    end
                    else if (pend_reg == "/" && c == "*")
                    begin
                        len_next = COUNT_WIDTH'(2);
                        mode_next = M_BLOCK;
                    end
                    else if (pend_reg == "-" && is_dig(c))
                    begin
                        len_next = COUNT_WIDTH'(2);
                        mode_next = M_NUMBER;
                    end
                    else if (pend_reg == "*" && c == "/")
                    begin
                        a_v = 1'b1;
                        a = mk_tok(KIND_ERROR, 5'd0, len_reg, trow_reg, tcol_reg);
                        do_start = 1'b1;
                    end
                    else
                    begin
                        a_v = 1'b1;
                        a = mk_tok(KIND_OPERATOR, pendl.idx, len_reg, trow_reg, tcol_reg);
                        do_start = 1'b1;
                    end
                end
                default: do_start = 1'b1;
            endcase
            if (do_start)
            begin
                trow_next = crow_reg;
                tcol_next = ccol_reg;
                len_next = COUNT_WIDTH'(1);
                mode_next = M_IDLE;
                if (is_ws(c))
                    len_next = '0;
                else if (c == "#")
                    mode_next = M_DIRECTIVE;
                else if (c == "/" || c == "-" || c == "*")
                begin
                    mode_next = M_PENDING;
                    pend_next = c;
                end
                else if (opl.hit)
                begin
                    b_v = 1'b1;
                    b = mk_tok(KIND_OPERATOR, opl.idx, COUNT_WIDTH'(1), crow_reg, ccol_reg);
                    len_next = '0;
                end
                else if (pnl.hit)
                begin
                    b_v = 1'b1;
                    b = mk_tok(KIND_PUNCT, pnl.idx, COUNT_WIDTH'(1), crow_reg, ccol_reg);
                    len_next = '0;
                end
                else if (is_dig(c))
                    mode_next = M_NUMBER;
                else if (is_alph(c))
                begin
                    word_next[0] = c;
                    mode_next = M_IDENT;
                end
                else
                begin
                    b_v = 1'b1;
                    b = mk_tok(KIND_ERROR, 5'd0, COUNT_WIDTH'(1), crow_reg, ccol_reg);
                    len_next = '0;
                end
            end
            if (c == 8'h0a)
            begin
                crow_next = sat_inc(crow_reg);
                ccol_next = '0;
            end
            else
                ccol_next = sat_inc(ccol_reg);
        end
    end

    always_comb
    begin
        rec.t0 = a_v ? a : b;
        rec.t1 = b;
        rec.two = a_v && b_v;
        rec.short_word = len_reg <= COUNT_WIDTH'(KEYWORD_MAX_LEN);
        for (int j = 0; j < WORD_BYTES; j++)
            rec.word[(WORD_BYTES-1-j)*8 +: 8] = word_reg[j];
        rec_valid = accept && (a_v || b_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            len_reg <= '0;
            trow_reg <= '0;
            tcol_reg <= '0;
            crow_reg <= '0;
            ccol_reg <= '0;
            pend_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            len_reg <= len_next;
            trow_reg <= trow_next;
            tcol_reg <= tcol_next;
            crow_reg <= crow_next;
            ccol_reg <= ccol_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            word_reg <= word_next;
    end

endmodule

// ----- src/cts_queue.sv -----
module cts_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cts_pkg::rec_t wr_rec,
    input  logic          deq,
    output cts_pkg::rec_t head,
    output logic          head_valid,
    output logic          full
);
    import cts_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    rec_t          mem [QUEUE_DEPTH];
    logic [PW-1:0] rd_reg, rd_next;
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW:0]   cnt_reg, cnt_next;
    logic          do_push, do_pop;

    always_comb
    begin
        do_push = push && !full;
        do_pop = deq && head_valid;
        rd_next = rd_reg + PW'(do_pop);
        wr_next = wr_reg + PW'(do_push);
        cnt_next = cnt_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
        full = cnt_reg == (PW+1)'(QUEUE_DEPTH);
        head_valid = cnt_reg != '0;
        head = mem[rd_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
            wr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg <= rd_next;
            wr_reg <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= wr_rec;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PW+1)'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != (PW+1)'(QUEUE_DEPTH)) |-> (PW'(wr_reg - rd_reg) == cnt_reg[PW-1:0]))
        else $error("queue pointers disagree with count");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue push lost");

endmodule

// ----- src/cts_back.sv -----
module cts_back #(
    parameter int KEYWORD_COUNT = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cts_pkg::rec_t head,
    input  logic          head_valid,
    output logic          deq,
    output cts_pkg::out_t result,
    output logic          empty,
    input  logic          pop
);
    import cts_pkg::*;

    logic    sel_reg, sel_next;
    tok_t    t;
    kw_t     kw;
    logic    hit, m;
    logic [4:0] hit_idx;
    logic [3:0] hit_size;

    always_comb
    begin
        t = sel_reg ? head.t1 : head.t0;
        hit = 1'b0;
        hit_idx = '0;
        hit_size = '0;
        for (int i = 0; i < KEYWORD_TABLE; i++)
        begin
            kw = kw_entry(5'(i));
            m = (i < KEYWORD_COUNT) && head.short_word && (t.len == 16'(kw.len));
            for (int j = 0; j < WORD_BYTES; j++)
                if (4'(j) < kw.len
                    && head.word[(WORD_BYTES-1-j)*8 +: 8] != kw.text[(WORD_BYTES-1-j)*8 +: 8])
                    m = 1'b0;
            if (m && !hit)
            begin
                hit = 1'b1;
                hit_idx = 5'(i);
                hit_size = kw.size;
            end
        end
        result.kind = t.kind;
        result.sub_code = t.sub;
        result.type_size = '0;
        if (t.kind == KIND_IDENT && hit && !sel_reg)
        begin
            result.kind = KIND_KEYWORD;
            result.sub_code = hit_idx;
            result.type_size = hit_size;
        end
        result.length = t.len;
        result.start_row = t.row;
        result.start_col = t.col;
        result.last = sel_reg || !head.two;
        empty = !head_valid;
        deq = pop && head_valid && result.last;
        sel_next = sel_reg;
        if (pop && head_valid)
            sel_next = !result.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= 1'b0;
        else
            sel_reg <= sel_next;
    end

    a_sel_pair: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> (head_valid && head.two))
        else $error("second token selected without a pair");

    a_deq_last: assert property (@(posedge clk) disable iff (!rst_n)
        deq |-> result.last)
        else $error("record retired before its last token");

    a_second_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_valid && !result.last) |=> sel_reg)
        else $error("second token of a pair skipped");

endmodule

// ----- src/c_token_scanner.sv -----
// Byte-serial C lexer. Source bytes enter on the item port (push/full), one
// item per cycle while full is low; end_of_text set closes any open token
// instead of a byte. Token records leave on the result port (empty/pop) in
// source order; the last field marks the final record from one input item.
// A byte that closes a token passes through the queue: the front scanner
// classifies it in the accept cycle and writes a record of up to two tokens
// into a four-entry queue, whose head the back end decodes (keyword lookup)
// and presents directly. Throughput is one byte per cycle while full is low;
// a byte giving two tokens takes two pops to drain, so sustained input is
// one item per cycle as long as results are popped at least as fast as they
// arise. When the receiver stalls, the queue fills and full rises once four
// records wait; bytes that produce no token are also held off while full.
// Reset clears the scanner to idle between tokens with row and column zero,
// and empties the queue.
module c_token_scanner #(
    parameter int KEYWORD_COUNT = 32,
    parameter int KEYWORD_MAX_LEN = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cts_pkg::in_t  item,
    input  logic          push,
    output logic          full,
    output cts_pkg::out_t result,
    output logic          empty,
    input  logic          pop
);
    import cts_pkg::*;

    rec_t rec, head;
    logic rec_valid, head_valid, deq, accept;

    assign accept = push && !full;

    cts_front #(
        .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .item(item),
        .accept(accept),
        .rec(rec),
        .rec_valid(rec_valid)
    );

    cts_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(rec_valid),
        .wr_rec(rec),
        .deq(deq),
        .head(head),
        .head_valid(head_valid),
        .full(full)
    );

    cts_back #(
        .KEYWORD_COUNT(KEYWORD_COUNT)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .head(head),
        .head_valid(head_valid),
        .deq(deq),
        .result(result),
        .empty(empty),
        .pop(pop)
    );

endmodule
